FILE: rtl/pcmsfc_pkg.sv
// Package for the PCM sample format converter: types, constants, functions.
// No dependencies.
package pcmsfc_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int SAMPLE_W         = 64;
    localparam int DEPTH_W          = 7;
    localparam int CHAN_W           = 4;
    localparam int KIND_W           = 2;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 64;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_DEPTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_DEPTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_CHAN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_CHAN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KIND      = 3'd4;

    localparam logic [KIND_W-1:0] KIND_UNSIGNED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SIGNED   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLOAT    = 2'd2;

    // Work item from front to back.
    typedef struct packed {
        logic                err;   // format error result
        logic                zero;  // zero-filled result
        logic                fend;  // last result channel
        logic [SAMPLE_W-1:0] data;  // sample or averaged value
    } t_item;

    typedef struct packed {
        logic [DEPTH_W-1:0] src_depth;
        logic [DEPTH_W-1:0] tgt_depth;
        logic [KIND_W-1:0]  kind;
    } t_conv_cfg;

    function automatic logic depth_ok(input logic [DEPTH_W-1:0] d);
        return (d == 7'd8) || (d == 7'd16) || (d == 7'd24) || (d == 7'd32) || (d == 7'd64);
    endfunction

    function automatic logic [SAMPLE_W-1:0] depth_mask(input logic [DEPTH_W-1:0] d);
        logic [SAMPLE_W-1:0] m;
        m = '1;
        if (d < 7'd64) m = ~({SAMPLE_W{1'b1}} << d[5:0]);
        return m;
    endfunction

endpackage

FILE: rtl/pcm_sample_format_converter_unit.sv
// PCM sample format converter, top level: config registers, front, queue, back.
// An accepted sample passes through the queue and the back end's output register to the master side.
// Throughput: one sample per cycle while the queue has room; the last sample of an upmix or short downmix
// frame is followed by a zero-fill burst, one item per zero-filled channel, during which no sample is taken.
// Reset (synchronous, active low) restores 16/16/2/2/0 and clears frame state and queues.
// A config write to one of the five registers clears the frame state. Depends on pcmsfc_pkg.
module pcm_sample_format_converter_unit #(
    parameter int MAX_CHANNELS = pcmsfc_pkg::MAX_CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] value
    output logic        m_axis_tlast,   // frame_end
    output logic        m_axis_tuser,   // format_error
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [pcmsfc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcmsfc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    logic [pcmsfc_pkg::DEPTH_W-1:0] r_src_depth, r_tgt_depth;
    logic [pcmsfc_pkg::CHAN_W-1:0]  r_src_chan, r_tgt_chan;
    logic [pcmsfc_pkg::KIND_W-1:0]  r_kind;
    logic cfg_wr, clr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid;

    // decode writes; an index past the list leaves the frame alone
    always_comb begin
        clr = 1'b0;
        if (cfg_wr) begin
            unique case (i_cfg_index)
                pcmsfc_pkg::REG_SRC_DEPTH, pcmsfc_pkg::REG_TGT_DEPTH,
                pcmsfc_pkg::REG_SRC_CHAN, pcmsfc_pkg::REG_TGT_CHAN,
                pcmsfc_pkg::REG_KIND: clr = 1'b1;
                default: clr = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_depth <= 7'd16; r_tgt_depth <= 7'd16;
            r_src_chan <= 4'd2; r_tgt_chan <= 4'd2; r_kind <= pcmsfc_pkg::KIND_UNSIGNED;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                pcmsfc_pkg::REG_SRC_DEPTH: r_src_depth <= i_cfg_data[6:0];
                pcmsfc_pkg::REG_TGT_DEPTH: r_tgt_depth <= i_cfg_data[6:0];
                pcmsfc_pkg::REG_SRC_CHAN:  r_src_chan  <= i_cfg_data[3:0];
                pcmsfc_pkg::REG_TGT_CHAN:  r_tgt_chan  <= i_cfg_data[3:0];
                pcmsfc_pkg::REG_KIND:      r_kind      <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic f_valid, f_ready, b_valid, b_ready;
    pcmsfc_pkg::t_item f_item, b_item;
    pcmsfc_pkg::t_conv_cfg ccfg;
    assign ccfg = '{src_depth: r_src_depth, tgt_depth: r_tgt_depth, kind: r_kind};

    // classify samples and produce work items
    pcmsfc_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(clr),
        .i_src_depth(r_src_depth), .i_tgt_depth(r_tgt_depth),
        .i_src_chan(r_src_chan), .i_tgt_chan(r_tgt_chan), .i_kind(r_kind),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_sample(s_axis_tdata),
        .o_valid(f_valid), .i_ready(f_ready), .o_item(f_item)
    );

    // decouple front and back
    pcmsfc_queue #(.DEPTH(2)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_item(f_item),
        .o_valid(b_valid), .i_ready(b_ready), .o_item(b_item)
    );

    // shift and encode into the output register
    pcmsfc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(ccfg),
        .i_valid(b_valid), .o_ready(b_ready), .i_item(b_item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_value(m_axis_tdata), .o_fend(m_axis_tlast), .o_err(m_axis_tuser)
    );
endmodule

FILE: rtl/pcmsfc_front.sv
// Front end: accepts samples, tracks frame position, downmix averaging and
// emits work items (including zero fill bursts). Depends on pcmsfc_pkg.
module pcmsfc_front #(
    parameter int MAX_CHANNELS = pcmsfc_pkg::MAX_CHANNELS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_clear,
    input  logic [pcmsfc_pkg::DEPTH_W-1:0]     i_src_depth,
    input  logic [pcmsfc_pkg::DEPTH_W-1:0]     i_tgt_depth,
    input  logic [pcmsfc_pkg::CHAN_W-1:0]      i_src_chan,
    input  logic [pcmsfc_pkg::CHAN_W-1:0]      i_tgt_chan,
    input  logic [pcmsfc_pkg::KIND_W-1:0]      i_kind,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [pcmsfc_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                               o_valid,
    input  logic                               i_ready,
    output pcmsfc_pkg::t_item                  o_item
);
    localparam int PW = pcmsfc_pkg::CHAN_W + 1;

    logic [PW-1:0] r_spos, n_spos, r_tpos, n_tpos, r_gcnt, n_gcnt;
    logic [pcmsfc_pkg::SAMPLE_W-1:0] r_acc, n_acc;
    logic r_fill, n_fill;   // zero-fill burst in progress
    logic fmt_ok, take, last, emit;
    logic [PW-1:0] s_ch, t_ch, grp;
    logic [pcmsfc_pkg::SAMPLE_W-1:0] s, avg;

    assign s_ch = {1'b0, i_src_chan};
    assign t_ch = {1'b0, i_tgt_chan};

    always_comb begin
        fmt_ok = pcmsfc_pkg::depth_ok(i_src_depth) && pcmsfc_pkg::depth_ok(i_tgt_depth)
              && (i_src_chan != '0) && (32'(i_src_chan) <= MAX_CHANNELS)
              && (i_tgt_chan != '0) && (32'(i_tgt_chan) <= MAX_CHANNELS);
        if (i_kind == pcmsfc_pkg::KIND_FLOAT) fmt_ok = fmt_ok && (i_tgt_depth == 7'd32);
        else if (i_kind != pcmsfc_pkg::KIND_UNSIGNED && i_kind != pcmsfc_pkg::KIND_SIGNED)
            fmt_ok = 1'b0;
    end

    // group size ceil(S/T) by repeated compare (S,T <= 15 so small table logic)
    always_comb begin
        grp = '0;
        for (int g = 1; g <= 16; g++) begin
            if (grp == '0 && (32'(g) * 32'(t_ch)) >= 32'(s_ch)) grp = PW'(g);
        end
    end

    assign s    = i_sample & pcmsfc_pkg::depth_mask(i_src_depth);
    assign avg  = (r_acc >> 1) + (s >> 1) + {63'd0, r_acc[0] & s[0]};
    assign last = (r_spos + PW'(1)) >= s_ch;
    assign o_ready = !r_fill && i_ready;
    assign take = i_valid && o_ready;

    always_comb begin
        n_spos = r_spos; n_tpos = r_tpos; n_gcnt = r_gcnt; n_acc = r_acc; n_fill = r_fill;
        o_valid = 1'b0;
        o_item  = '0;
        emit    = 1'b0;
        if (r_fill) begin
            o_valid = 1'b1;
            o_item.zero = 1'b1;
            o_item.fend = (r_tpos == t_ch - PW'(1));
            if (i_ready) begin
                n_tpos = r_tpos + PW'(1);
                if (n_tpos >= t_ch) begin
                    n_fill = 1'b0; n_tpos = '0;
                end
            end
        end else if (!fmt_ok) begin
            o_valid = i_valid;
            o_item.err = 1'b1;
            if (take) begin
                n_spos = '0; n_tpos = '0; n_gcnt = '0; n_acc = '0;
            end
        end else if (s_ch <= t_ch) begin
            o_valid = i_valid;
            o_item.data = s;
            o_item.fend = last && (s_ch == t_ch);
            if (take) begin
                n_tpos = r_spos + PW'(1);
                n_spos = r_spos + PW'(1);
                if (last) begin
                    n_spos = '0;
                    if (n_tpos < t_ch) n_fill = 1'b1;
                    else n_tpos = '0;
                end
            end
        end else begin
            emit = ((r_gcnt + PW'(1)) >= grp || last) && (r_tpos < t_ch);
            o_valid = i_valid && emit;
            o_item.data = avg;
            o_item.fend = (r_tpos == t_ch - PW'(1));
            if (take) begin
                n_acc = avg; n_gcnt = r_gcnt + PW'(1);
                if ((r_gcnt + PW'(1)) >= grp || last) begin
                    n_acc = '0; n_gcnt = '0;
                    if (r_tpos < t_ch) n_tpos = r_tpos + PW'(1);
                end
                n_spos = r_spos + PW'(1);
                if (last) begin
                    n_spos = '0;
                    if (n_tpos < t_ch) n_fill = 1'b1;
                    else n_tpos = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_spos <= '0; r_tpos <= '0; r_gcnt <= '0; r_acc <= '0; r_fill <= 1'b0;
        end else begin
            r_spos <= n_spos; r_tpos <= n_tpos; r_gcnt <= n_gcnt;
            r_acc <= n_acc; r_fill <= n_fill;
        end
    end
endmodule

FILE: rtl/pcmsfc_queue.sv
// Short FIFO between front and back ends. Depends on pcmsfc_pkg.
module pcmsfc_queue #(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  pcmsfc_pkg::t_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output pcmsfc_pkg::t_item  o_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    pcmsfc_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic wr, rd;

    assign o_ready = (32'(r_cnt) < DEPTH);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (32'(r_wp) == DEPTH - 1) ? '0 : r_wp + AW'(1);
            if (rd) r_rp <= (32'(r_rp) == DEPTH - 1) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule

FILE: rtl/pcmsfc_back.sv
// Back end: depth shift and encoding into an output register.
// Depends on pcmsfc_pkg.
module pcmsfc_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pcmsfc_pkg::t_conv_cfg              i_cfg,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  pcmsfc_pkg::t_item                  i_item,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [pcmsfc_pkg::SAMPLE_W-1:0]    o_value,
    output logic                               o_fend,
    output logic                               o_err
);
    logic r_valid;
    logic [pcmsfc_pkg::SAMPLE_W-1:0] r_value, n_value;
    logic r_fend, r_err;
    logic [pcmsfc_pkg::SAMPLE_W-1:0] v;
    logic [31:0] m, fbits;
    logic        neg;
    logic [4:0]  lz;
    logic [7:0]  ex;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        if (i_cfg.tgt_depth < i_cfg.src_depth)
            v = i_item.data >> (i_cfg.src_depth - i_cfg.tgt_depth);
        else
            v = i_item.data << (i_cfg.tgt_depth - i_cfg.src_depth);
        v = v & pcmsfc_pkg::depth_mask(i_cfg.tgt_depth);
        // float: read the low 32 bits as a signed number s and scale by 2^-31;
        // magnitude of s up to 2^31, rounded to a 24-bit mantissa.
        neg = v[31];
        m   = neg ? (32'h8000_0000 - {1'b0, v[30:0]}) : {1'b0, v[30:0]};
        lz  = '0;
        for (int b = 0; b < 32; b++) if (m[b]) lz = 5'(b);
        fbits = '0;
        ex    = '0;
        if (m != '0) begin
            logic [31:0] nm;
            logic [24:0] man;
            logic        rb, st;
            nm  = m << (5'd31 - lz);
            man = {1'b0, nm[31:8]};
            rb  = nm[7];
            st  = |nm[6:0];
            if (rb && (st || man[0])) man = man + 25'd1;
            ex = 8'd96 + {3'd0, lz};
            if (man[24]) begin
                ex = ex + 8'd1; man = man >> 1;
            end
            fbits = {neg, ex, man[22:0]};
        end
        unique case (i_cfg.kind)
            pcmsfc_pkg::KIND_SIGNED:
                n_value = v ^ (64'd1 << (i_cfg.tgt_depth - 7'd1));
            pcmsfc_pkg::KIND_FLOAT:
                n_value = {32'd0, fbits};
            default: n_value = v;
        endcase
        if (i_item.zero || i_item.err) n_value = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (o_ready) r_valid <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_value <= n_value; r_fend <= i_item.fend; r_err <= i_item.err;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_fend  = r_fend;
    assign o_err   = r_err;
endmodule
